// ===== sv/uts_pkg.sv =====
// shared types, constants and the decimal digit step for the uart segment generator
package uts_pkg;

  // request kinds carried on the input tuser
  typedef enum logic [1:0] {
    CMD_BYTE     = 2'd0,
    CMD_BYTE_GAP = 2'd1,
    CMD_NUMBER   = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  // segment positions inside one frame plus its trailing gap
  localparam logic [3:0] SEG_START = 4'd0;
  localparam logic [3:0] SEG_STOP  = 4'd9;
  localparam logic [3:0] SEG_GAP   = 4'd10;

  // last digit position of a number request
  localparam logic [1:0] DIGIT_LAST = 2'd3;

  localparam logic [15:0] BIT_TIME_RESET = 16'd81;
  localparam logic [15:0] GAP_TIME_RESET = 16'd200;
  localparam logic [13:0] NUMBER_MAX     = 14'd9999;
  localparam logic [7:0]  ASCII_ZERO     = 8'd48;

  // configuration register indexes
  localparam logic CFG_BIT_TIME = 1'b0;
  localparam logic CFG_GAP_TIME = 1'b1;

  typedef struct packed {
    logic [15:0] bit_time;
    logic [15:0] gap_time;
  } cfg_t;

  // one registered request
  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  data_byte;
    logic [13:0] number;
    logic        final_byte;
  } item_t;

  typedef struct packed {
    logic [3:0]  digit;
    logic [13:0] rem;
  } digit_t;

  // weight of a digit position, most significant first
  function automatic logic [13:0] digit_scale(input logic [1:0] pos);
    logic [13:0] s;
    begin
      case (pos)
        2'd0:    s = 14'd1000;
        2'd1:    s = 14'd100;
        2'd2:    s = 14'd10;
        default: s = 14'd1;
      endcase
      return s;
    end
  endfunction

  // one decimal digit from a value below ten times the position weight
  function automatic digit_t digit_step(input logic [13:0] v, input logic [1:0] pos);
    digit_t      r;
    logic [13:0] s;
    logic [17:0] thr;
    begin
      s = digit_scale(pos);
      r.digit = 4'd0;
      r.rem   = v;
      for (int k = 1; k <= 9; k++) begin
        thr = 18'(k) * {4'd0, s};
        if ({4'd0, v} >= thr) begin
          r.digit = 4'(k);
          r.rem   = v - thr[13:0];
        end
      end
      return r;
    end
  endfunction

endpackage

// ===== sv/uts_in_stage.sv =====
// input register: takes one request beat, clamps the number, drops unused commands
module uts_in_stage
  import uts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  cmd_t        in_cmd,
  input  logic [7:0]  in_byte,
  input  logic [13:0] in_number,
  input  logic        in_final,
  output logic        held_valid,
  output item_t       held_item,
  input  logic        take
);

  logic  full;
  item_t item;
  logic  accept;

  assign in_ready   = !full || take;
  assign accept     = in_valid && in_ready;
  assign held_valid = full;
  assign held_item  = item;

  // occupancy: unused commands leave nothing behind
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (accept) begin
      full <= (in_cmd != CMD_UNUSED);
    end else if (take) begin
      full <= 1'b0;
    end
  end

  // payload with the number clamped to four digits
  always_ff @(posedge clk) begin
    if (accept) begin
      item.cmd        <= in_cmd;
      item.data_byte  <= in_byte;
      item.number     <= (in_number > NUMBER_MAX) ? NUMBER_MAX : in_number;
      item.final_byte <= in_final;
    end
  end

endmodule

// ===== sv/uts_seg_seq.sv =====
// segment sequencer: walks frames and gaps of one request, one segment a cycle unless the output stalls
module uts_seg_seq
  import uts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        held_valid,
  input  item_t       held_item,
  output logic        take,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_level,
  output logic [16:0] out_hold,
  output logic        out_last,
  output logic        out_msg_end
);

  logic        busy;
  cmd_t        cmd;
  logic [7:0]  frame_byte;
  logic [13:0] rem;
  logic [1:0]  digit_pos;
  logic [3:0]  seg;
  logic        fin;

  logic        emit;
  logic        seg_last;
  logic        seg_level;
  logic [16:0] seg_hold;
  logic        load;
  digit_t      first_digit;
  digit_t      next_digit;
  logic [1:0]  digit_pos_next;

  // segment decode
  always_comb begin
    case (seg)
      SEG_START:        seg_level = 1'b0;
      SEG_STOP, SEG_GAP: seg_level = 1'b1;
      default:          seg_level = frame_byte[3'(seg - 4'd1)];
    endcase
    seg_hold = (seg == SEG_GAP) ? ({1'b0, cfg.gap_time} + 17'd1)
                                : ({1'b0, cfg.bit_time} + 17'd1);
    case (cmd)
      CMD_BYTE:     seg_last = (seg == SEG_STOP);
      CMD_BYTE_GAP: seg_last = (seg == SEG_GAP);
      default:      seg_last = (seg == SEG_GAP) && (digit_pos == DIGIT_LAST);
    endcase
  end

  // handshake between request register, sequencer and output register
  assign emit = busy && (!out_valid || out_ready);
  assign load = !busy || (emit && seg_last);
  assign take = load && held_valid;

  // digit extraction, one position per frame
  assign digit_pos_next = digit_pos + 2'd1;
  assign first_digit    = digit_step(held_item.number, 2'd0);
  assign next_digit     = digit_step(rem, digit_pos_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= held_valid;
    end
  end

  // sequencer position and current frame byte
  always_ff @(posedge clk) begin
    if (take) begin
      cmd       <= held_item.cmd;
      fin       <= held_item.final_byte;
      seg       <= SEG_START;
      digit_pos <= 2'd0;
      rem       <= first_digit.rem;
      if (held_item.cmd == CMD_NUMBER) begin
        frame_byte <= ASCII_ZERO + {4'd0, first_digit.digit};
      end else begin
        frame_byte <= held_item.data_byte;
      end
    end else if (emit && !seg_last) begin
      if (seg == SEG_GAP) begin
        seg        <= SEG_START;
        digit_pos  <= digit_pos_next;
        rem        <= next_digit.rem;
        frame_byte <= ASCII_ZERO + {4'd0, next_digit.digit};
      end else begin
        seg <= seg + 4'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_level   <= seg_level;
      out_hold    <= seg_hold;
      out_last    <= seg_last;
      out_msg_end <= seg_last && fin;
    end
  end

endmodule

// ===== sv/uart_tx_segment_generator.sv =====
// top level of the uart 8n1 segment generator
//
// channel   direction  beat contents
// s_axis    in         tdata: data_byte, number_value; tuser: command; tlast: final_byte
// m_axis    out        tdata: line_level, hold_ticks; tuser: message_end; tlast: last
// cfg       in         cfg_index selects bit_time or gap_time, cfg_data is the value
//
// one segment leaves per cycle unless m_axis stalls; a request is 10, 11 or 44 segments
// (bare byte, byte with gap, four-digit number), set by the single segment sequencer.
// the next request waits in the input register, so requests go back to back.
// reset empties both registers and loads bit_time 81, gap_time 200.
// a stall on m_axis holds the output register and, once that fills, the sequencer.
module uart_tx_segment_generator
  import uts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // data_byte [7:0], number_value [21:8], zero [23:22]
  input  logic [1:0]  s_axis_tuser,  // command [1:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // line_level [0], hold_ticks [17:1], zero [23:18]
  output logic        m_axis_tuser,  // message_end [0]
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t        cfg;
  logic        held_valid;
  item_t       held_item;
  logic        take;
  logic        out_level;
  logic [16:0] out_hold;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_time <= BIT_TIME_RESET;
      cfg.gap_time <= GAP_TIME_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BIT_TIME: cfg.bit_time <= cfg_data;
        CFG_GAP_TIME: cfg.gap_time <= cfg_data;
        default:      ;
      endcase
    end
  end

  uts_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_cmd     (cmd_t'(s_axis_tuser)),
    .in_byte    (s_axis_tdata[7:0]),
    .in_number  (s_axis_tdata[21:8]),
    .in_final   (s_axis_tlast),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (take)
  );

  uts_seg_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .held_valid  (held_valid),
    .held_item   (held_item),
    .take        (take),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_level   (out_level),
    .out_hold    (out_hold),
    .out_last    (m_axis_tlast),
    .out_msg_end (m_axis_tuser)
  );

  assign m_axis_tdata = {6'd0, out_hold, out_level};

`ifndef SYNTHESIS
  // message_end only rides on the closing segment of a run
  a_msg_end_on_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("message_end without last");

  // every segment is held at least one tick
  a_hold_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[17:1] != 17'd0)
    else $error("zero hold time");

  // a run never ends on a low level: stop bit or gap closes it
  a_last_high: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[0])
    else $error("run ends low");

  // the request register is taken only when it holds a request
  a_take_full: assert property (@(posedge clk) disable iff (rst)
    take |-> held_valid)
    else $error("take from empty request register");
`endif

endmodule
